### hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types for the sorted key table
// Operation codes, transaction payloads and the control word broadcast to
// every cell of the table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int POS_W = 7;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_FIND_KEY = 2'd2,
    OP_FIND_POS = 2'd3
  } skt_op_t;

  typedef struct packed {
    skt_op_t                   operation;
    logic signed [KEY_W-1:0]   key_in;
    logic        [PAY_W-1:0]   payload_in;
    logic        [POS_W-1:0]   position;
  } skt_op_item_t;

  typedef struct packed {
    logic                      ok;
    logic signed [KEY_W-1:0]   key_out;
    logic        [PAY_W-1:0]   payload_out;
    logic        [CNT_OUT_W-1:0] entry_count;
    logic                      is_empty;
    logic                      is_full;
  } skt_res_item_t;

  // broadcast to all cells: compare fields on accept, shift fields on commit
  typedef struct packed {
    logic                      cmp_en;
    skt_op_t                   cmp_op;
    logic signed [KEY_W-1:0]   cmp_key;
    logic        [POS_W-1:0]   cmp_pos;
    logic                      ins_en;
    logic                      rem_en;
    logic        [KEY_W-1:0]   new_key;
    logic        [PAY_W-1:0]   new_payload;
  } skt_ctl_t;

endpackage

### hw/rtl/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if: valid/ready channels of the sorted key table
// One interface for operation transactions, one for result transactions.
// ----------------------------------------------------------------------------
interface skt_op_if
  import skt_pkg::*;
();
  logic         valid;
  logic         ready;
  skt_op_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface skt_res_if
  import skt_pkg::*;
();
  logic          valid;
  logic          ready;
  skt_res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: signed-key table kept in ascending order
// Insert, remove by key, lookup by key and lookup by position over a row of
// CAPACITY cells, each holding one key and its payload word.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+-----------------------------------------
//  in_op   | in  | valid/ready        | operation, key_in, payload_in, position
//  out_res | out | valid/ready        | ok, key_out, payload_out, entry_count,
//          |     |                    | is_empty, is_full
//
//  For each transaction, on the accept edge every cell compares its key
//  (or its slot number) with the probe and registers its flags; on the
//  commit edge the row shifts by one cell and the result register loads.
//  The one-hot select across the cells for lookups feeds the result register.
//  Reset clears the entry count and the flags; cell contents are not cleared.
//  A result not yet taken holds the table in its commit cycle, and in_op.ready
//  stays low until that transaction has committed.
//
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  skt_op_if.sink   in_op,
  skt_res_if.source out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } skt_state_t;

  skt_state_t state_r, state_nxt;

  // operation held for the commit cycle
  skt_op_t          op_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] payload_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  skt_res_item_t    res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  logic in_acc;
  logic commit;
  logic found;
  logic not_full;
  logic is_lookup;

  skt_ctl_t ctl;

  // per-cell wiring; each element is one cell's own output
  logic             ge_now_w  [CAPACITY];
  logic             ge_w      [CAPACITY];
  logic             pick_w    [CAPACITY];
  logic [KEY_W-1:0] cell_key  [CAPACITY];
  logic [PAY_W-1:0] cell_pay  [CAPACITY];
  logic [CAPACITY-1:0] pick_vec;
  logic [KEY_W-1:0] sel_key;
  logic [PAY_W-1:0] sel_pay;

  assign in_op.ready = (state_r == ST_IDLE);
  assign in_acc      = in_op.valid && in_op.ready;
  assign commit      = (state_r == ST_BUSY) && (!res_valid_r || out_res.ready);
  assign not_full    = count_r < CNT_FULL;
  assign is_lookup   = (op_r == OP_FIND_KEY) || (op_r == OP_FIND_POS);

  always_comb begin
    ctl.cmp_en      = in_acc;
    ctl.cmp_op      = in_op.data.operation;
    ctl.cmp_key     = in_op.data.key_in;
    ctl.cmp_pos     = in_op.data.position;
    ctl.ins_en      = commit && (op_r == OP_INSERT) && not_full;
    ctl.rem_en      = commit && (op_r == OP_REMOVE) && found;
    ctl.new_key     = key_r;
    ctl.new_payload = payload_r;
  end

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             l_ge_now;
    logic             l_ge;
    logic [KEY_W-1:0] l_key;
    logic [PAY_W-1:0] l_pay;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;

    if (i == 0) begin : g_head
      assign l_ge_now = 1'b0;
      assign l_ge     = 1'b0;
      assign l_key    = '0;
      assign l_pay    = '0;
    end else begin : g_mid
      assign l_ge_now = ge_now_w[i-1];
      assign l_ge     = ge_w[i-1];
      assign l_key    = cell_key[i-1];
      assign l_pay    = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key = '0;
      assign r_pay = '0;
    end else begin : g_body
      assign r_key = cell_key[i+1];
      assign r_pay = cell_pay[i+1];
    end

    skt_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .count         (count_r),
      .left_ge_now   (l_ge_now),
      .left_ge       (l_ge),
      .left_key      (l_key),
      .left_payload  (l_pay),
      .right_key     (r_key),
      .right_payload (r_pay),
      .ge_now        (ge_now_w[i]),
      .ge_r          (ge_w[i]),
      .pick_r        (pick_w[i]),
      .key_r         (cell_key[i]),
      .payload_r     (cell_pay[i])
    );
  end

  // at most one cell is picked, so an AND-OR select is enough
  always_comb begin
    found   = 1'b0;
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick_vec[i] = pick_w[i];
      found   = found | pick_w[i];
      sel_key = sel_key | (cell_key[i] & {KEY_W{pick_w[i]}});
      sel_pay = sel_pay | (cell_pay[i] & {PAY_W{pick_w[i]}});
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rem_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    case (op_r)
      OP_INSERT: res_nxt.ok = not_full;
      default:   res_nxt.ok = found;
    endcase
    res_nxt.key_out     = (is_lookup && found) ? $signed(sel_key) : '0;
    res_nxt.payload_out = (is_lookup && found) ? sel_pay : '0;
    res_nxt.entry_count = CNT_OUT_W'(count_nxt);
    res_nxt.is_empty    = count_nxt == '0;
    res_nxt.is_full     = count_nxt == CNT_FULL;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (commit) begin
      res_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_op.data.operation;
      key_r     <= in_op.data.key_in;
      payload_r <= in_op.data.payload_in;
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid = res_valid_r;
  assign out_res.data  = res_r;

  // ---- assertions ----------------------------------------------------------

  // count never runs past the number of cells
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above capacity");

  // a key or position lookup selects at most one cell
  a_pick_single : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> $onehot0(pick_vec))
    else $error("more than one cell picked");

  // an insert that commits grows the table by exactly one
  a_insert_grow : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow table by one");

  // a commit always leaves a result waiting and the block ready again
  a_commit_res : assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (res_valid_r && state_r == ST_IDLE))
    else $error("commit without result");

endmodule

### hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one entry, compares it with the broadcast key and shifts to or from
// its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  skt_ctl_t         ctl,
  input  logic [CNT_W-1:0] count,
  input  logic             left_ge_now,
  input  logic             left_ge,
  input  logic [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0] left_payload,
  input  logic [KEY_W-1:0] right_key,
  input  logic [PAY_W-1:0] right_payload,
  output logic             ge_now,
  output logic             ge_r,
  output logic             pick_r,
  output logic [KEY_W-1:0] key_r,
  output logic [PAY_W-1:0] payload_r
);

  localparam int PW = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;
  localparam logic [CNT_W-1:0] SLOT  = CNT_W'(IDX);
  localparam logic [PW-1:0]    SLOT1 = PW'(IDX + 1);

  logic             valid;
  logic             at_end;
  logic             hit;
  logic             pos_hit;
  logic             pick_now;
  logic             ge_nxt;
  logic             pick_nxt;
  logic [KEY_W-1:0] key_nxt;
  logic [PAY_W-1:0] payload_nxt;

  assign valid  = SLOT < count;
  assign at_end = SLOT == count;

  // entries at or past the first key >= probe form a suffix of the table
  assign ge_now  = valid && !($signed(key_r) < ctl.cmp_key);
  assign hit     = ge_now && (key_r == ctl.cmp_key) && !left_ge_now;
  assign pos_hit = valid && (PW'(ctl.cmp_pos) == SLOT1);

  always_comb begin
    case (ctl.cmp_op)
      OP_REMOVE,
      OP_FIND_KEY: pick_now = hit;
      OP_FIND_POS: pick_now = pos_hit;
      default:     pick_now = 1'b0;
    endcase
  end

  assign ge_nxt   = ctl.cmp_en ? ge_now   : ge_r;
  assign pick_nxt = ctl.cmp_en ? pick_now : pick_r;

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctl.ins_en) begin
      if (left_ge) begin
        key_nxt     = left_key;
        payload_nxt = left_payload;
      end else if (ge_r || at_end) begin
        key_nxt     = ctl.new_key;
        payload_nxt = ctl.new_payload;
      end
    end else if (ctl.rem_en && ge_r) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r   <= 1'b0;
      pick_r <= 1'b0;
    end else begin
      ge_r   <= ge_nxt;
      pick_r <= pick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

endmodule
